### sv/bn_pkg.sv
// ----------------------------------------------------------------------------
// bn_pkg
// Shared constants and types for the batch normalization block.
// ----------------------------------------------------------------------------
`default_nettype none
package bn_pkg;
	localparam int CHANNELS    = 1024;
	localparam int CH_W        = $clog2(CHANNELS);
	localparam int RSQRT_STEPS = 16;
	localparam int S_W         = 25;
	localparam int ACC_W       = 41;

	localparam logic [15:0] EPS_RESET = 16'd66;

	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_NORM = 1'b1
	} func_t;

	typedef struct packed {
		func_t              func;
		logic [CH_W-1:0]    ch;
		logic signed [15:0] sample;
		logic signed [15:0] mean;
		logic signed [15:0] gamma;
		logic signed [15:0] beta;
	} item_t;
endpackage
`default_nettype wire

### sv/bn_if.sv
// ----------------------------------------------------------------------------
// bn_req_if / bn_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
`default_nettype none
interface bn_req_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic [9:0]         channel_index;
	logic signed [15:0] sample_value;
	logic signed [15:0] mean_value;
	logic [23:0]        variance_value;
	logic signed [15:0] gamma_value;
	logic signed [15:0] beta_value;
	modport source (output valid, func, channel_index, sample_value, mean_value,
		variance_value, gamma_value, beta_value, input ready);
	modport sink (input valid, func, channel_index, sample_value, mean_value,
		variance_value, gamma_value, beta_value, output ready);
endinterface

interface bn_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] normalized_value;
	logic [9:0]         result_channel;
	logic               saturated_flag;
	modport source (output valid, normalized_value, result_channel, saturated_flag,
		input ready);
	modport sink (input valid, normalized_value, result_channel, saturated_flag,
		output ready);
endinterface
`default_nettype wire

### sv/bn_rsqrt.sv
// ----------------------------------------------------------------------------
// bn_rsqrt
// Pipelined inverse square root, one result bit per stage; requests ride along.
// ----------------------------------------------------------------------------
`default_nettype none
module bn_rsqrt
	import bn_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             in_valid,
	input  wire item_t            in_item,
	input  wire logic [S_W-1:0]   in_s,
	output logic                  out_valid,
	output item_t                 out_item,
	output logic [15:0]           out_inv
);
	// acc = r*r*s, bs = r*s
	logic             v_s   [0:RSQRT_STEPS];
	item_t            it_s  [0:RSQRT_STEPS];
	logic [S_W-1:0]   s_s   [0:RSQRT_STEPS];
	logic [ACC_W-1:0] acc_s [0:RSQRT_STEPS];
	logic [ACC_W-1:0] bs_s  [0:RSQRT_STEPS];
	logic [15:0]      r_s   [0:RSQRT_STEPS];

	assign v_s[0]   = in_valid;
	assign it_s[0]  = in_item;
	assign s_s[0]   = in_s;
	assign acc_s[0] = '0;
	assign bs_s[0]  = '0;
	assign r_s[0]   = '0;

	for (genvar k = 0; k < RSQRT_STEPS; k++) begin : g_stage
		logic [ACC_W-1:0] acc_n, bs_n;
		logic [15:0]      r_n;
		if (k < 16) begin : g_bit
			logic [63:0] cand;
			logic        keep;
			assign cand = 64'(acc_s[k]) + (64'(bs_s[k]) << (16 - k))
				+ (64'(s_s[k]) << (30 - 2 * k));
			assign keep  = cand <= (64'd1 << 40);
			assign acc_n = keep ? cand[ACC_W-1:0] : acc_s[k];
			assign bs_n  = keep ? bs_s[k] + (ACC_W'(s_s[k]) << (15 - k)) : bs_s[k];
			assign r_n   = keep ? (r_s[k] | (16'd1 << (15 - k))) : r_s[k];
		end else begin : g_pass
			assign acc_n = acc_s[k];
			assign bs_n  = bs_s[k];
			assign r_n   = r_s[k];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				it_s[k+1]  <= it_s[k];
				s_s[k+1]   <= s_s[k];
				acc_s[k+1] <= acc_n;
				bs_s[k+1]  <= bs_n;
				r_s[k+1]   <= r_n;
			end
		end
	end

	assign out_valid = v_s[RSQRT_STEPS];
	assign out_item  = it_s[RSQRT_STEPS];
	assign out_inv   = r_s[RSQRT_STEPS];
endmodule
`default_nettype wire

### sv/bn_pstore.sv
// ----------------------------------------------------------------------------
// bn_pstore
// Per-channel parameter memories: loads write, samples read.
// ----------------------------------------------------------------------------
`default_nettype none
module bn_pstore
	import bn_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire logic          in_valid,
	input  wire item_t         in_item,
	input  wire logic [15:0]   in_inv,
	output logic               v_s1,
	output logic [CH_W-1:0]    ch_s1,
	output logic signed [15:0] sample_s1,
	output logic signed [15:0] mean_s1,
	output logic [15:0]        inv_s1,
	output logic signed [15:0] gamma_s1,
	output logic signed [15:0] beta_s1
);
	logic [15:0] mean_mem  [0:CHANNELS-1];
	logic [15:0] inv_mem   [0:CHANNELS-1];
	logic [15:0] gamma_mem [0:CHANNELS-1];
	logic [15:0] beta_mem  [0:CHANNELS-1];

	always_ff @(posedge clk) begin
		if (adv && in_valid && in_item.func == FUNC_LOAD) begin
			mean_mem[in_item.ch]  <= in_item.mean;
			inv_mem[in_item.ch]   <= in_inv;
			gamma_mem[in_item.ch] <= in_item.gamma;
			beta_mem[in_item.ch]  <= in_item.beta;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mean_s1   <= mean_mem[in_item.ch];
			inv_s1    <= inv_mem[in_item.ch];
			gamma_s1  <= gamma_mem[in_item.ch];
			beta_s1   <= beta_mem[in_item.ch];
			ch_s1     <= in_item.ch;
			sample_s1 <= in_item.sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid && in_item.func == FUNC_NORM;
		end
	end
endmodule
`default_nettype wire

### sv/bn_arith.sv
// ----------------------------------------------------------------------------
// bn_arith
// Three-stage normalize: (x-mean)*inv, *gamma+beta, round and saturate.
// ----------------------------------------------------------------------------
`default_nettype none
module bn_arith
	import bn_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire logic               in_valid,
	input  wire logic [CH_W-1:0]    in_ch,
	input  wire logic signed [15:0] in_sample,
	input  wire logic signed [15:0] in_mean,
	input  wire logic [15:0]        in_inv,
	input  wire logic signed [15:0] in_gamma,
	input  wire logic signed [15:0] in_beta,
	output logic                    out_valid,
	output logic signed [15:0]      out_value,
	output logic [CH_W-1:0]         out_ch,
	output logic                    out_sat
);
	logic               v_s1, v_s2;
	logic [CH_W-1:0]    ch_s1, ch_s2;
	logic signed [33:0] p_s1;
	logic signed [15:0] gamma_s1, beta_s1;
	logic signed [50:0] t_s2;
	logic signed [16:0] d;
	logic signed [50:0] u;
	logic signed [30:0] val;

	assign d   = 17'(in_sample) - 17'(in_mean);
	assign u   = t_s2 + 51'sd524288;
	assign val = u[50:20];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1     <= 34'(d) * $signed({18'd0, in_inv});
			gamma_s1 <= in_gamma;
			beta_s1  <= in_beta;
			ch_s1    <= in_ch;
			t_s2     <= 51'(p_s1) * 51'(gamma_s1) + {{15{beta_s1[15]}}, beta_s1, 20'd0};
			ch_s2    <= ch_s1;
			out_ch   <= ch_s2;
			if (val > 31'sd32767) begin
				out_value <= 16'sh7FFF;
				out_sat   <= 1'b1;
			end else if (val < -31'sd32768) begin
				out_value <= 16'sh8000;
				out_sat   <= 1'b1;
			end else begin
				out_value <= val[15:0];
				out_sat   <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

### sv/batch_norm_inference.sv
// ----------------------------------------------------------------------------
// batch_norm_inference
// Per-channel fixed-point batch normalization with parameter loading.
// ----------------------------------------------------------------------------
// channel   dir   carries
// req       in    load (func 0) or sample (func 1) request
// rsp       out   normalized sample, channel, saturation flag
// cfg       in    epsilon write (cfg_we, cfg_wdata)
//
// One request per cycle while rsp is not stalled; a sample result passes through
// 16 inverse-root stages, one memory read and three arithmetic stages.
// Loads give no result. A sample sees every earlier load.
// A stall on rsp freezes the whole pipeline; nothing is dropped.
// Reset clears valid bits and sets epsilon to 66; memories are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module batch_norm_inference
	import bn_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic [15:0] cfg_wdata,
	bn_req_if.sink     req,
	bn_rsp_if.source   rsp
);
	logic [15:0]        eps_q;
	logic               adv;
	item_t              item;
	logic               rs_valid;
	item_t              rs_item;
	logic [15:0]        rs_inv;
	logic               ps_v;
	logic [CH_W-1:0]    ps_ch;
	logic signed [15:0] ps_sample, ps_mean, ps_gamma, ps_beta;
	logic [15:0]        ps_inv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end

	assign adv       = !rsp.valid || rsp.ready;
	assign req.ready = adv;

	assign item.func   = func_t'(req.func);
	assign item.ch     = req.channel_index;
	assign item.sample = req.sample_value;
	assign item.mean   = req.mean_value;
	assign item.gamma  = req.gamma_value;
	assign item.beta   = req.beta_value;

	bn_rsqrt u_rsqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (req.valid),
		.in_item   (item),
		.in_s      (S_W'(req.variance_value) + S_W'(eps_q)),
		.out_valid (rs_valid),
		.out_item  (rs_item),
		.out_inv   (rs_inv)
	);

	bn_pstore u_pstore (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (rs_valid),
		.in_item   (rs_item),
		.in_inv    (rs_inv),
		.v_s1      (ps_v),
		.ch_s1     (ps_ch),
		.sample_s1 (ps_sample),
		.mean_s1   (ps_mean),
		.inv_s1    (ps_inv),
		.gamma_s1  (ps_gamma),
		.beta_s1   (ps_beta)
	);

	bn_arith u_arith (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (ps_v),
		.in_ch     (ps_ch),
		.in_sample (ps_sample),
		.in_mean   (ps_mean),
		.in_inv    (ps_inv),
		.in_gamma  (ps_gamma),
		.in_beta   (ps_beta),
		.out_valid (rsp.valid),
		.out_value (rsp.normalized_value),
		.out_ch    (rsp.result_channel),
		.out_sat   (rsp.saturated_flag)
	);

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.saturated_flag |->
		rsp.normalized_value == 16'sh7FFF || rsp.normalized_value == 16'sh8000)
		else $error("saturated result not at range limit");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(ps_v) && $stable(rs_valid))
		else $error("pipeline moved during stall");

	a_load_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		adv && rs_valid && rs_item.func == FUNC_LOAD |=> !ps_v)
		else $error("load request produced a result");
endmodule
`default_nettype wire
